// ===== src/led_dimmer_ramp_controller_top_assert.svh =====
// Assertion macros shared by the LED dimmer RTL.
// Expects i_clk and the active-low synchronous reset i_rst_n in the including scope.
`ifndef LED_DIMMER_RAMP_CONTROLLER_TOP_ASSERT_SVH
`define LED_DIMMER_RAMP_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LDRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ldrc_pkg.sv =====
// Package for the LED dimmer: event codes, result struct, widths and constants.
// Also holds the elaboration-time builder of the exponential PWM curve ROM.
package ldrc_pkg;

    localparam int unsigned ROM_DEPTH = 1024;
    localparam int unsigned ROM_AW    = 10;
    localparam int unsigned LEVEL_W   = 11;
    localparam int unsigned PWM_W     = 8;
    localparam int unsigned REQ_W     = 12;
    localparam int unsigned PERIOD_W  = 8;

    localparam logic [LEVEL_W-1:0]  LEVEL_TOP        = 11'd1300;
    localparam logic [LEVEL_W-1:0]  LEVEL_CLAMP      = 11'd1023;
    localparam logic [PERIOD_W-1:0] DIM_PERIOD_RESET = 8'd3;
    localparam logic [PERIOD_W-1:0] TICK_SAT         = 8'd255;
    localparam logic [63:0]         Q31_ONE          = 64'h0000_0000_8000_0000;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_TOGGLE    = 3'd1,
        OP_DIM_START = 3'd2,
        OP_DIM_STOP  = 3'd3,
        OP_SET_LEVEL = 3'd4,
        OP_SET_ON    = 3'd5
    } t_opcode;

    typedef logic [PWM_W-1:0] t_rom [ROM_DEPTH];

    typedef struct packed {
        logic               drive_valid;
        logic               drive_on;
        logic [LEVEL_W-1:0] dim_level;
        logic               lamp_on;
    } t_evt_res;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] nv;
        logic [63:0] res;
        logic [63:0] b;
        nv  = n_in;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        while (b > nv) b = b >> 2;
        while (b != 64'd0) begin
            if (nv >= res + b) begin
                nv  = nv - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Entry v holds floor(PWM_MAX^((v+1)/1024)) - 1, computed in Q1.31 fixed point,
    // exact where the exponent lands on an integer root of PWM_MAX.
    function automatic t_rom build_rom(input int unsigned pwm_max);
        t_rom        rom;
        logic [63:0] c [32];
        logic [63:0] p;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] x;
        logic [63:0] ip;
        logic [63:0] acc;
        logic [63:0] k;
        logic [63:0] pwm;
        logic [63:0] o;
        logic [63:0] r;
        logic [63:0] q;
        int unsigned n;
        int unsigned j;
        int unsigned e;
        int unsigned t;
        int unsigned s;
        logic [63:0] i;
        logic        exact;
        p = 64'(pwm_max);
        if (p < 64'd1) p = 64'd1;
        if (p > 64'd65535) p = 64'd65535;
        c[0] = 64'd0;
        c[1] = isqrt64(64'h8000_0000_0000_0000);
        for (j = 1; j < 31; j++) c[j+1] = isqrt64(c[j] << 31);
        n = 0;
        while (n < 15 && (p >> (n + 1)) != 64'd0) n++;
        m  = p << (31 - n);
        lg = 64'(n) << 31;
        for (j = 1; j <= 31; j++) begin
            m = (m * m) >> 31;
            if (m >= (Q31_ONE << 1)) begin
                m  = m >> 1;
                lg = lg | (64'd1 << (31 - j));
            end
        end
        for (e = 1; e <= ROM_DEPTH; e++) begin
            o     = 64'(e);
            r     = p;
            t     = 10;
            exact = 1'b1;
            while (o[0] == 1'b0) begin
                o = o >> 1;
                t--;
            end
            for (s = 0; s < t && exact; s++) begin
                q = isqrt64(r);
                if (q * q != r) exact = 1'b0;
                else r = q;
            end
            if (exact) begin
                k = 64'd1;
                for (i = 64'd0; i < o; i++) k = k * r;
            end else begin
                x   = (lg * 64'(e)) >> 10;
                ip  = x >> 31;
                acc = Q31_ONE;
                for (j = 1; j <= 31; j++) begin
                    if (x[31-j]) acc = (acc * c[j]) >> 31;
                end
                k = (acc << ip) >> 31;
            end
            pwm = (k > 64'd0) ? k - 64'd1 : 64'd0;
            if (pwm > p) pwm = p;
            rom[e-1] = pwm[PWM_W-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== src/led_dimmer_ramp_controller_top.sv =====
// LED dimmer top level: one event in per transaction, one result out per event.
// The event is decoded and the state updated in the cycle it is accepted, and the
// PWM duty is read from a registered 1024-entry curve ROM in the next cycle and the
// result is registered for output. A new event can be taken every cycle unless the
// output stalls; throughput is bounded only by the output handshake. Depends on
// ldrc_pkg, ldrc_ctrl, ldrc_curve_rom, led_dimmer_ramp_controller_top_assert.svh.
`include "led_dimmer_ramp_controller_top_assert.svh"

module led_dimmer_ramp_controller_top #(
    parameter int unsigned PWM_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: level_value[11:0], new_state[12], zero fill [15:13].
    input  logic [15:0] s_axis_tdata,
    // Fields from bit 0: opcode[2:0].
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: drive_on[0], pwm_level[8:1], dim_level[19:9],
    // lamp_on[20], zero fill [23:21].
    output logic [23:0] m_axis_tdata,
    // Fields from bit 0: drive_valid[0].
    output logic        m_axis_tuser
);

    logic                             w_in_acc;
    logic                             w_adv;
    ldrc_pkg::t_evt_res               w_res;
    logic [ldrc_pkg::ROM_AW-1:0]      w_rom_addr;
    logic [ldrc_pkg::PWM_W-1:0]       w_rom_data;
    logic                             r_p1_valid;
    ldrc_pkg::t_evt_res               r_p1_res;
    logic                             r_out_valid;
    ldrc_pkg::t_evt_res               r_out_res;
    logic [ldrc_pkg::PWM_W-1:0]       r_out_pwm;

    assign w_adv         = r_p1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_p1_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    ldrc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_evt_en      (w_in_acc),
        .i_opcode      (s_axis_tuser),
        .i_level_value (s_axis_tdata[11:0]),
        .i_new_state   (s_axis_tdata[12]),
        .o_res         (w_res),
        .o_rom_addr    (w_rom_addr)
    );

    ldrc_curve_rom #(
        .PWM_MAX (PWM_MAX)
    ) u_rom (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_rom_addr),
        .o_rd_data (w_rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_p1_valid <= 1'b1;
        end else if (w_adv) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p1_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= r_p1_res;
            r_out_pwm <= r_p1_res.drive_on ? w_rom_data : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.drive_valid;
    assign m_axis_tdata  = {3'b000, r_out_res.lamp_on, r_out_res.dim_level,
                            r_out_pwm, r_out_res.drive_on};

    `LDRC_ASSERT_NXT(a_p1_held, r_p1_valid && !w_adv, r_p1_valid, "Pending ROM read was dropped.")
    `LDRC_ASSERT_IMP(a_pwm_off, r_out_valid && !r_out_res.drive_on, r_out_pwm == '0, "PWM duty nonzero while drive is low.")
    `LDRC_ASSERT_IMP(a_drive_lamp, r_out_valid && r_out_res.drive_on, r_out_res.lamp_on && r_out_res.drive_valid, "Drive active without lamp on or drive write.")
    `LDRC_ASSERT_IMP(a_level_range, r_out_valid, r_out_res.dim_level <= ldrc_pkg::LEVEL_TOP, "Dim level above top of ramp.")

endmodule

// ===== src/ldrc_curve_rom.sv =====
// Exponential PWM curve ROM with a registered read port.
// Contents come from ldrc_pkg::build_rom at elaboration.
module ldrc_curve_rom #(
    parameter int unsigned PWM_MAX = 255
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [ldrc_pkg::ROM_AW-1:0]  i_rd_addr,
    output logic [ldrc_pkg::PWM_W-1:0]   o_rd_data
);

    localparam ldrc_pkg::t_rom CURVE = ldrc_pkg::build_rom(PWM_MAX);

    logic [ldrc_pkg::PWM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= CURVE[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ldrc_ctrl.sv =====
// Dimmer state and event decode: on flag, dimming flag, ramp direction, level,
// tick counter and the dim_period register. Uses ldrc_pkg.
module ldrc_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [ldrc_pkg::PERIOD_W-1:0]    i_cfg_wr_data,
    input  logic                             i_evt_en,
    input  logic [2:0]                       i_opcode,
    input  logic signed [ldrc_pkg::REQ_W-1:0] i_level_value,
    input  logic                             i_new_state,
    output ldrc_pkg::t_evt_res               o_res,
    output logic [ldrc_pkg::ROM_AW-1:0]      o_rom_addr
);

    logic [ldrc_pkg::PERIOD_W-1:0] r_dim_period;
    logic                          r_lamp;
    logic                          n_lamp;
    logic                          r_dimming;
    logic                          n_dimming;
    logic                          r_down;
    logic                          n_down;
    logic [ldrc_pkg::LEVEL_W-1:0]  r_level;
    logic [ldrc_pkg::LEVEL_W-1:0]  n_level;
    logic [ldrc_pkg::PERIOD_W-1:0] r_tick;
    logic [ldrc_pkg::PERIOD_W-1:0] n_tick;
    logic                          w_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_period <= ldrc_pkg::DIM_PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_dim_period <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp    <= 1'b0;
            r_dimming <= 1'b0;
            r_down    <= 1'b0;
            r_level   <= '0;
            r_tick    <= '0;
        end else if (i_evt_en) begin
            r_lamp    <= n_lamp;
            r_dimming <= n_dimming;
            r_down    <= n_down;
            r_level   <= n_level;
            r_tick    <= n_tick;
        end
    end

    always_comb begin
        n_lamp    = r_lamp;
        n_dimming = r_dimming;
        n_down    = r_down;
        n_level   = r_level;
        n_tick    = r_tick;
        w_drive   = 1'b0;
        unique case (i_opcode)
            ldrc_pkg::OP_TICK: begin
                if (r_tick != ldrc_pkg::TICK_SAT) begin
                    n_tick = r_tick + 1'b1;
                end
                if (r_dimming && n_tick >= r_dim_period) begin
                    n_tick  = '0;
                    w_drive = 1'b1;
                    if (r_down) begin
                        if (r_level <= ldrc_pkg::LEVEL_W'(1)) begin
                            n_level = ldrc_pkg::LEVEL_W'(1);
                            n_down  = 1'b0;
                        end else begin
                            n_level = r_level - 1'b1;
                        end
                    end else begin
                        if (r_level >= ldrc_pkg::LEVEL_TOP) begin
                            n_level = ldrc_pkg::LEVEL_TOP;
                            n_down  = 1'b1;
                        end else begin
                            n_level = r_level + 1'b1;
                        end
                    end
                end
            end
            ldrc_pkg::OP_TOGGLE: begin
                n_lamp  = !r_lamp;
                w_drive = 1'b1;
            end
            ldrc_pkg::OP_DIM_START: begin
                n_dimming = 1'b1;
                if (!r_lamp) begin
                    n_down  = 1'b0;
                    n_level = '0;
                    n_lamp  = 1'b1;
                end else begin
                    n_down = !r_down;
                    if (r_level > ldrc_pkg::LEVEL_CLAMP) begin
                        n_level = ldrc_pkg::LEVEL_CLAMP;
                    end
                end
            end
            ldrc_pkg::OP_DIM_STOP: begin
                n_dimming = 1'b0;
            end
            ldrc_pkg::OP_SET_LEVEL: begin
                w_drive = 1'b1;
                if (i_level_value <= $signed(12'sd0)) begin
                    n_level = '0;
                end else if (i_level_value > $signed(12'sd1023)) begin
                    n_level = ldrc_pkg::LEVEL_CLAMP;
                end else begin
                    n_level = ldrc_pkg::LEVEL_W'(i_level_value[ldrc_pkg::ROM_AW-1:0]);
                end
            end
            ldrc_pkg::OP_SET_ON: begin
                n_lamp  = i_new_state;
                w_drive = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.drive_valid = w_drive;
        o_res.drive_on    = w_drive && n_lamp && (n_level != '0);
        o_res.dim_level   = n_level;
        o_res.lamp_on     = n_lamp;
        if (n_level > ldrc_pkg::LEVEL_CLAMP) begin
            o_rom_addr = ldrc_pkg::LEVEL_CLAMP[ldrc_pkg::ROM_AW-1:0];
        end else begin
            o_rom_addr = n_level[ldrc_pkg::ROM_AW-1:0];
        end
    end

endmodule

// ===== test/led_dimmer_ramp_controller_top_tb.sv =====
// Self-checking testbench for led_dimmer_ramp_controller_top: a directed event table, then
// random ramp, hold and bounce sequences, checked with an in-bench dimmer model or,
// for marked directed rows, fixed expected results. Depends on ldrc_pkg and the dimmer RTL.
module led_dimmer_ramp_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PWM_MAX     = 255;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  OP_RSVD6    = 3'd6;
    localparam logic [2:0]  OP_RSVD7    = 3'd7;
    localparam logic [7:0]  TOP_DUTY    = 8'(PWM_MAX - 1);

    typedef struct packed {
        logic                         drive_valid;
        logic                         drive_on;
        logic [ldrc_pkg::PWM_W-1:0]   pwm_level;
        logic [ldrc_pkg::LEVEL_W-1:0] dim_level;
        logic                         lamp_on;
    } t_dim_result;

    typedef struct packed {
        logic [2:0]                 op;
        logic [ldrc_pkg::REQ_W-1:0] lvl;
        logic                       ns;
        logic                       fixed_exp;
        t_dim_result                want;
    } t_dir_row;

    localparam t_dim_result NO_RES = '0;
    localparam int N_DIRECTED = 26;
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd0, 1'b0}},
        '{ldrc_pkg::OP_TOGGLE, 12'h000, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, 11'd0, 1'b1}},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h7FF, 1'b0, 1'b1, '{1'b1, 1'b1, TOP_DUTY, 11'd1023, 1'b1}},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h800, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd0, 11'd0, 1'b1}},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h000, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, 11'd0, 1'b1}},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h001, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h400, 1'b0, 1'b1, '{1'b1, 1'b1, TOP_DUTY, 11'd1023, 1'b1}},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h200, 1'b1, 1'b0, NO_RES},
        '{ldrc_pkg::OP_SET_ON, 12'hFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, 11'd512, 1'b0}},
        '{ldrc_pkg::OP_SET_ON, 12'h000, 1'b1, 1'b0, NO_RES},
        '{ldrc_pkg::OP_DIM_START, 12'h000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd512, 1'b1}},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_DIM_STOP, 12'h000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd511, 1'b1}},
        '{OP_RSVD6, 12'hFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd511, 1'b1}},
        '{OP_RSVD7, 12'h7FF, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd511, 1'b1}},
        '{ldrc_pkg::OP_TOGGLE, 12'h000, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, 11'd511, 1'b0}},
        '{ldrc_pkg::OP_DIM_START, 12'h000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd0, 1'b1}},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_DIM_START, 12'h000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0, 11'd1, 1'b1}},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_TICK, 12'h000, 1'b0, 1'b0, NO_RES},
        '{ldrc_pkg::OP_SET_LEVEL, 12'h555, 1'b1, 1'b0, NO_RES}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;
    logic [2:0]  s_axis_tuser = 3'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic        row_fixed = 1'b0;
    t_dim_result row_want = '0;

    logic [ldrc_pkg::PWM_W-1:0]   duty_curve [ldrc_pkg::ROM_DEPTH];
    logic [7:0]                   period_q  = ldrc_pkg::DIM_PERIOD_RESET;
    logic                         lamp_q    = 1'b0;
    logic                         dimming_q = 1'b0;
    logic                         down_q    = 1'b0;
    logic [ldrc_pkg::LEVEL_W-1:0] lvl_q     = '0;
    logic [7:0]                   ticks_q   = 8'd0;

    t_dim_result pending_q [$];
    int          errors = 0;
    int          n_sent = 0;
    int          cycles = 0;
    int          tx_idle_pct = 19;
    int          rx_idle_pct = 62;

    led_dimmer_ramp_controller_top #(
        .PWM_MAX(PWM_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] sqrt_floor(input logic [63:0] val);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= val) root = trial;
        end
        return root;
    endfunction

    // Duty curve: PWM_MAX^((v+1)/1024) - 1, computed in Q31 fixed point, exact on integer roots.
    function automatic void build_duty_curve();
        logic [63:0] root2 [32];
        logic [63:0] base;
        logic [63:0] mant;
        logic [63:0] log_q;
        logic [63:0] expo;
        logic [63:0] whole;
        logic [63:0] acc;
        logic [63:0] kval;
        logic [63:0] duty;
        logic [63:0] odd;
        logic [63:0] rt;
        logic [63:0] sq;
        int unsigned msb;
        int unsigned halvings;
        logic        exact;
        base = 64'(PWM_MAX);
        if (base < 64'd1) base = 64'd1;
        if (base > 64'd65535) base = 64'd65535;
        root2[0] = 64'd0;
        root2[1] = sqrt_floor(64'h8000_0000_0000_0000);
        for (int j = 1; j < 31; j++) root2[j+1] = sqrt_floor(root2[j] << 31);
        msb = 0;
        while (msb < 15 && (base >> (msb + 1)) != 64'd0) msb++;
        mant  = base << (31 - msb);
        log_q = 64'(msb) << 31;
        for (int j = 1; j <= 31; j++) begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000) begin
                mant  = mant >> 1;
                log_q = log_q | (64'd1 << (31 - j));
            end
        end
        for (int e = 1; e <= ldrc_pkg::ROM_DEPTH; e++) begin
            odd      = 64'(e);
            halvings = 10;
            exact    = 1'b1;
            rt       = base;
            while (!odd[0]) begin
                odd = odd >> 1;
                halvings--;
            end
            for (int s = 0; s < halvings && exact; s++) begin
                sq = sqrt_floor(rt);
                if (sq * sq != rt) exact = 1'b0;
                else rt = sq;
            end
            if (exact) begin
                kval = 64'd1;
                for (longint unsigned i = 0; i < odd; i++) kval = kval * rt;
            end else begin
                expo  = (log_q * 64'(e)) >> 10;
                whole = expo >> 31;
                acc   = 64'h8000_0000;
                for (int j = 1; j <= 31; j++) begin
                    if (expo[31-j]) acc = (acc * root2[j]) >> 31;
                end
                kval = (acc << whole) >> 31;
            end
            duty = (kval > 64'd0) ? kval - 64'd1 : 64'd0;
            if (duty > base) duty = base;
            duty_curve[e-1] = duty[ldrc_pkg::PWM_W-1:0];
        end
    endfunction

    function automatic t_dim_result drive_word();
        t_dim_result res;
        res = '0;
        res.drive_valid = 1'b1;
        if (lamp_q && lvl_q != '0) begin
            res.drive_on  = 1'b1;
            res.pwm_level = duty_curve[(lvl_q > ldrc_pkg::LEVEL_CLAMP) ?
                                       ldrc_pkg::LEVEL_CLAMP[9:0] : lvl_q[9:0]];
        end
        return res;
    endfunction

    task automatic apply_event(input logic [2:0] op, input logic [ldrc_pkg::REQ_W-1:0] lv,
                               input logic ns, output t_dim_result res);
        int req;
        res = '0;
        req = int'($signed(lv));
        case (op)
            ldrc_pkg::OP_TICK: begin
                if (ticks_q != ldrc_pkg::TICK_SAT) ticks_q = ticks_q + 8'd1;
                if (dimming_q && ticks_q >= period_q) begin
                    ticks_q = 8'd0;
                    if (down_q) begin
                        if (lvl_q <= 11'd1) begin
                            lvl_q  = 11'd1;
                            down_q = 1'b0;
                        end else begin
                            lvl_q = lvl_q - 11'd1;
                        end
                    end else if (lvl_q >= ldrc_pkg::LEVEL_TOP) begin
                        lvl_q  = ldrc_pkg::LEVEL_TOP;
                        down_q = 1'b1;
                    end else begin
                        lvl_q = lvl_q + 11'd1;
                    end
                    res = drive_word();
                end
            end
            ldrc_pkg::OP_TOGGLE: begin
                lamp_q = !lamp_q;
                res    = drive_word();
            end
            ldrc_pkg::OP_DIM_START: begin
                dimming_q = 1'b1;
                if (!lamp_q) begin
                    down_q = 1'b0;
                    lvl_q  = '0;
                    lamp_q = 1'b1;
                end else begin
                    down_q = !down_q;
                    if (lvl_q > ldrc_pkg::LEVEL_CLAMP) lvl_q = ldrc_pkg::LEVEL_CLAMP;
                end
            end
            ldrc_pkg::OP_DIM_STOP: dimming_q = 1'b0;
            ldrc_pkg::OP_SET_LEVEL: begin
                if (req <= 0) lvl_q = '0;
                else if (req > int'(ldrc_pkg::LEVEL_CLAMP)) lvl_q = ldrc_pkg::LEVEL_CLAMP;
                else lvl_q = ldrc_pkg::LEVEL_W'(req);
                res = drive_word();
            end
            ldrc_pkg::OP_SET_ON: begin
                lamp_q = ns;
                res    = drive_word();
            end
            default: ;
        endcase
        res.dim_level = lvl_q;
        res.lamp_on   = lamp_q;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_dim_result pred;
        t_dim_result want;
        t_dim_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_event(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[12], pred);
                pending_q.push_back(row_fixed ? row_want : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[0], m_axis_tdata[8:1],
                        m_axis_tdata[19:9], m_axis_tdata[20]};
                if (pending_q.size() == 0) begin
                    $error("unexpected result transaction: %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = pending_q.pop_front();
                    if (got.drive_valid !== want.drive_valid) begin
                        $error("drive_valid: expected %0d, actual %0d",
                               want.drive_valid, got.drive_valid);
                        errors++;
                    end
                    if (got.drive_on !== want.drive_on) begin
                        $error("drive_on: expected %0d, actual %0d", want.drive_on, got.drive_on);
                        errors++;
                    end
                    if (got.pwm_level !== want.pwm_level) begin
                        $error("pwm_level: expected %0d, actual %0d",
                               want.pwm_level, got.pwm_level);
                        errors++;
                    end
                    if (got.dim_level !== want.dim_level) begin
                        $error("dim_level: expected %0d, actual %0d",
                               want.dim_level, got.dim_level);
                        errors++;
                    end
                    if (got.lamp_on !== want.lamp_on) begin
                        $error("lamp_on: expected %0d, actual %0d", want.lamp_on, got.lamp_on);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_event(input logic [2:0] op, input logic [ldrc_pkg::REQ_W-1:0] lv,
                              input logic ns, input logic fixed_exp,
                              input t_dim_result want);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, ns, lv};
        row_fixed     <= fixed_exp;
        row_want      <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_RSVD6 && op != OP_RSVD7) n_sent++;
    endtask

    task automatic send_random_op();
        send_event(3'($urandom_range(7, 0)), 12'($urandom), 1'($urandom), 1'b0, NO_RES);
    endtask

    task automatic write_period(input logic [7:0] val);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        period_q = val;
    endtask

    function automatic logic [ldrc_pkg::REQ_W-1:0] pick_level();
        case ($urandom_range(2, 0))
            0:       return ldrc_pkg::REQ_W'($urandom_range(40, 0));
            1:       return ldrc_pkg::REQ_W'($urandom_range(1023, 985));
            default: return ldrc_pkg::REQ_W'($urandom);
        endcase
    endfunction

    // Mostly ramp sequences: optional power-on and level preset, a dim start, then a
    // long run of ticks sprinkled with stray events. The rest idles or injects noise.
    task automatic run_random(input int n_items);
        int start_cnt;
        int burst;
        int pick;
        start_cnt = n_sent;
        while (n_sent - start_cnt < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                if ($urandom_range(9, 0) < 7)
                    send_event(ldrc_pkg::OP_SET_ON, 12'($urandom), 1'b1, 1'b0, NO_RES);
                if ($urandom_range(9, 0) < 6)
                    send_event(ldrc_pkg::OP_SET_LEVEL, pick_level(), 1'($urandom), 1'b0,
                               NO_RES);
                send_event(ldrc_pkg::OP_DIM_START, 12'($urandom), 1'($urandom), 1'b0, NO_RES);
                burst = (period_q <= 8'd1) ? $urandom_range(320, 1) : $urandom_range(60, 1);
                repeat (burst) begin
                    if ($urandom_range(99, 0) < 4) send_random_op();
                    else send_event(ldrc_pkg::OP_TICK, 12'($urandom), 1'($urandom), 1'b0,
                                    NO_RES);
                end
                if ($urandom_range(1, 0) == 0)
                    send_event(ldrc_pkg::OP_DIM_STOP, 12'($urandom), 1'($urandom), 1'b0,
                               NO_RES);
            end else if (pick < 80) begin
                send_event(ldrc_pkg::OP_DIM_STOP, 12'($urandom), 1'($urandom), 1'b0, NO_RES);
                repeat ($urandom_range(300, 1))
                    send_event(ldrc_pkg::OP_TICK, 12'($urandom), 1'($urandom), 1'b0, NO_RES);
            end else begin
                repeat ($urandom_range(6, 1)) send_random_op();
            end
        end
    endtask

    initial begin
        build_duty_curve();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_event(DIRECTED[i].op, DIRECTED[i].lvl, DIRECTED[i].ns,
                       DIRECTED[i].fixed_exp, DIRECTED[i].want);
        end

        write_period(8'd1);
        run_random(300);
        write_period(8'd0);
        run_random(250);

        write_period(8'd255);
        tx_idle_pct = 62;
        rx_idle_pct = 19;
        run_random(200);
        write_period(8'($urandom_range(9, 2)));
        run_random(250);

        write_period(8'd2);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(250);
        write_period(8'd1);
        run_random(130);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        errors += pending_q.size();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ldrc_pkg.sv
src/ldrc_curve_rom.sv
src/ldrc_ctrl.sv
src/led_dimmer_ramp_controller_top.sv
test/led_dimmer_ramp_controller_top_tb.sv
